### src/assert_macros.svh
// Assertion macros for the checker file of the bar aggregator.
// Every macro samples on aclk; the first one ignores cycles in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while aresetn is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Concurrent assertion that also holds through reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### src/ohlc_pkg.sv
// Shared widths, the period reset constant and control structs for the bar aggregator.
// Used by every module of the block but ohlc_div; depends on nothing.
package ohlc_pkg;

    localparam int TIME_W   = 53;
    localparam int PERIOD_W = 37;
    localparam int PRICE_W  = 24;
    localparam int SPREAD_W = 16;
    localparam int TICKS_W  = 32;
    localparam int TOTAL_W  = 48;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(60000000);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the incoming word
        logic div_start;  // launch both dividers
        logic commit;     // emit the closed bar if any and update the forming bar
    } ohlc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_busy;
        logic close_needed;
        logic out_free;
    } ohlc_stat_t;

endpackage

### src/ohlc_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Standalone; no package needed.
module ohlc_div #(
    parameter int N = 53,
    parameter int D = 37
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [N-1:0] dividend,
    input  logic [D-1:0] divisor,
    output logic         busy,
    output logic [N-1:0] quot,
    output logic [D-1:0] rem
);

    localparam int CNT_W = $clog2(N + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             busy_reg, busy_next;
    logic [N-1:0]     quot_reg, quot_next;
    logic [D-1:0]     rem_reg, rem_next;
    logic [D-1:0]     dvs_reg, dvs_next;
    logic [D:0]       trial;
    logic [D+1:0]     diff;

    // The quotient register starts out holding the dividend and shifts it out.
    assign trial = {rem_reg, quot_reg[N-1]};
    assign diff  = {1'b0, trial} - {2'b00, dvs_reg};

    always_comb begin
        count_next = count_reg;
        busy_next  = busy_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        if (start) begin
            count_next = CNT_W'(N);
            busy_next  = 1'b1;
            quot_next  = dividend;
            rem_next   = '0;
            dvs_next   = divisor;
        end else if (busy_reg) begin
            if (diff[D+1]) begin
                rem_next  = trial[D-1:0];
                quot_next = {quot_reg[N-2:0], 1'b0};
            end else begin
                rem_next  = diff[D-1:0];
                quot_next = {quot_reg[N-2:0], 1'b1};
            end
            count_next = count_reg - CNT_W'(1);
            if (count_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            busy_reg  <= busy_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign busy = busy_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

### src/ohlc_ctrl.sv
// Sequencer of the bar aggregator: takes a word, waits on the dividers, commits.
// Depends on ohlc_pkg for the command and status structs.
module ohlc_ctrl
    import ohlc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  ohlc_stat_t stat,
    output ohlc_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RUN    = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next    = state_reg;
        cmd.load      = accept;
        cmd.div_start = accept;
        cmd.commit    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (!stat.div_busy) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                // A closing bar has to wait until the result register is free.
                if (!stat.close_needed || stat.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### src/ohlc_dp.sv
// Datapath of the bar aggregator: period register, forming bar, dividers, result register.
// Depends on ohlc_pkg and instantiates ohlc_div twice.
module ohlc_dp
    import ohlc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [PERIOD_W-1:0] cfg_wdata,
    input  logic [TIME_W-1:0]   s_tick_time,
    input  logic [PRICE_W-1:0]  s_bid_price,
    input  logic [SPREAD_W-1:0] s_spread,
    input  ohlc_cmd_t           cmd,
    output ohlc_stat_t          stat,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [TIME_W-1:0]   m_bar_start,
    output logic [PRICE_W-1:0]  m_open_price,
    output logic [PRICE_W-1:0]  m_high_price,
    output logic [PRICE_W-1:0]  m_low_price,
    output logic [PRICE_W-1:0]  m_close_price,
    output logic [TICKS_W-1:0]  m_tick_count,
    output logic [SPREAD_W-1:0] m_spread_mean,
    output logic [SPREAD_W-1:0] m_spread_peak
);

    logic [PERIOD_W-1:0] period_reg;
    logic [TIME_W-1:0]   in_time_reg;
    logic [PRICE_W-1:0]  in_bid_reg;
    logic [SPREAD_W-1:0] in_spr_reg;

    logic                active_reg;
    logic [TIME_W-1:0]   start_reg;
    logic [PRICE_W-1:0]  open_reg, high_reg, low_reg, close_reg;
    logic [TICKS_W-1:0]  ticks_reg;
    logic [TOTAL_W-1:0]  total_reg;
    logic [SPREAD_W-1:0] smax_reg;

    logic                out_valid_reg;
    logic [TIME_W-1:0]   out_start_reg;
    logic [PRICE_W-1:0]  out_open_reg, out_high_reg, out_low_reg, out_close_reg;
    logic [TICKS_W-1:0]  out_ticks_reg;
    logic [SPREAD_W-1:0] out_mean_reg, out_peak_reg;

    logic [PERIOD_W-1:0] period_eff;
    logic [PERIOD_W-1:0] floor_rem;
    logic                floor_busy;
    logic [TOTAL_W-1:0]  mean_quot;
    logic                mean_busy;
    logic [TIME_W-1:0]   start_calc;
    logic                close_needed;
    logic                fresh;
    logic [SPREAD_W-1:0] mean_val;
    logic [TOTAL_W:0]    total_sum;

    // A period of zero behaves as a period of one.
    assign period_eff = (period_reg == '0) ? PERIOD_W'(1) : period_reg;

    ohlc_div #(
        .N (TIME_W),
        .D (PERIOD_W)
    ) u_floor_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (s_tick_time),
        .divisor  (period_eff),
        .busy     (floor_busy),
        .quot     (),
        .rem      (floor_rem)
    );

    // The mean of the forming bar is worked out for every word, needed or not.
    ohlc_div #(
        .N (TOTAL_W),
        .D (TICKS_W)
    ) u_mean_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (total_reg),
        .divisor  (ticks_reg),
        .busy     (mean_busy),
        .quot     (mean_quot),
        .rem      ()
    );

    assign start_calc   = in_time_reg - {{(TIME_W-PERIOD_W){1'b0}}, floor_rem};
    assign close_needed = active_reg && (start_calc != start_reg);
    assign fresh        = !active_reg || close_needed;
    assign total_sum    = {1'b0, total_reg} + {{(TOTAL_W+1-SPREAD_W){1'b0}}, in_spr_reg};

    always_comb begin
        if (ticks_reg == '0) begin
            mean_val = '0;
        end else if (|mean_quot[TOTAL_W-1:SPREAD_W]) begin
            mean_val = '1;
        end else begin
            mean_val = mean_quot[SPREAD_W-1:0];
        end
    end

    assign stat.div_busy     = floor_busy || mean_busy;
    assign stat.close_needed = close_needed;
    assign stat.out_free     = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= PERIOD_RESET;
        end else if (cfg_we) begin
            period_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            in_time_reg <= s_tick_time;
            in_bid_reg  <= s_bid_price;
            in_spr_reg  <= s_spread;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            start_reg  <= '0;
            open_reg   <= '0;
            high_reg   <= '0;
            low_reg    <= '0;
            close_reg  <= '0;
            ticks_reg  <= '0;
            total_reg  <= '0;
            smax_reg   <= '0;
        end else if (cmd.commit) begin
            active_reg <= 1'b1;
            close_reg  <= in_bid_reg;
            if (fresh) begin
                start_reg <= start_calc;
                open_reg  <= in_bid_reg;
                high_reg  <= in_bid_reg;
                low_reg   <= in_bid_reg;
                ticks_reg <= TICKS_W'(1);
                total_reg <= TOTAL_W'(in_spr_reg);
                smax_reg  <= in_spr_reg;
            end else begin
                if (in_bid_reg > high_reg) begin
                    high_reg <= in_bid_reg;
                end
                if (in_bid_reg < low_reg) begin
                    low_reg <= in_bid_reg;
                end
                if (ticks_reg != '1) begin
                    ticks_reg <= ticks_reg + TICKS_W'(1);
                end
                total_reg <= total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
                if (in_spr_reg > smax_reg) begin
                    smax_reg <= in_spr_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.commit && close_needed) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && close_needed) begin
            out_start_reg <= start_reg;
            out_open_reg  <= open_reg;
            out_high_reg  <= high_reg;
            out_low_reg   <= low_reg;
            out_close_reg <= close_reg;
            out_ticks_reg <= ticks_reg;
            out_mean_reg  <= mean_val;
            out_peak_reg  <= smax_reg;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_bar_start   = out_start_reg;
    assign m_open_price  = out_open_reg;
    assign m_high_price  = out_high_reg;
    assign m_low_price   = out_low_reg;
    assign m_close_price = out_close_reg;
    assign m_tick_count  = out_ticks_reg;
    assign m_spread_mean = out_mean_reg;
    assign m_spread_peak = out_peak_reg;

endmodule

### src/tick_to_ohlc_bar_aggregator_core.sv
// Channel   Direction  Handshake          Word
// s_        in         s_valid/s_ready    tick_time, bid_price, spread
// m_        out        m_valid/m_ready    closed bar: start, OHLC, count, mean, peak
// cfg_      in         cfg_we             bar period in microseconds
//
// Words are accepted one at a time: after the accepting edge the radix-2 divider that floors
// the timestamp works out one quotient bit per edge, then the sequencer sees it done and
// commits the word. s_ready stays low from an acceptance until that word is committed.
// The mean spread is divided in parallel and finishes no later than the timestamp floor.
// Reset is synchronous on aresetn and clears the forming bar and the result register.
// A closed bar waits in the result register; only a second close stalls the commit.
// Depends on ohlc_pkg, ohlc_ctrl and ohlc_dp.
module tick_to_ohlc_bar_aggregator_core
    import ohlc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [PERIOD_W-1:0] cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [TIME_W-1:0]   s_tick_time,
    input  logic [PRICE_W-1:0]  s_bid_price,
    input  logic [SPREAD_W-1:0] s_spread,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [TIME_W-1:0]   m_bar_start,
    output logic [PRICE_W-1:0]  m_open_price,
    output logic [PRICE_W-1:0]  m_high_price,
    output logic [PRICE_W-1:0]  m_low_price,
    output logic [PRICE_W-1:0]  m_close_price,
    output logic [TICKS_W-1:0]  m_tick_count,
    output logic [SPREAD_W-1:0] m_spread_mean,
    output logic [SPREAD_W-1:0] m_spread_peak
);

    ohlc_cmd_t  cmd;
    ohlc_stat_t stat;

    ohlc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ohlc_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_tick_time   (s_tick_time),
        .s_bid_price   (s_bid_price),
        .s_spread      (s_spread),
        .cmd           (cmd),
        .stat          (stat),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_bar_start   (m_bar_start),
        .m_open_price  (m_open_price),
        .m_high_price  (m_high_price),
        .m_low_price   (m_low_price),
        .m_close_price (m_close_price),
        .m_tick_count  (m_tick_count),
        .m_spread_mean (m_spread_mean),
        .m_spread_peak (m_spread_peak)
    );

endmodule

### src/ohlc_chk.sv
// Port-level checker for the bar aggregator, bound to the top level.
// Depends on ohlc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ohlc_chk
    import ohlc_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic [TIME_W-1:0]   m_bar_start,
    input logic [PRICE_W-1:0]  m_high_price,
    input logic [PRICE_W-1:0]  m_low_price,
    input logic [TICKS_W-1:0]  m_tick_count
);

    // A stalled result word must stay put.
    `ASSERT_CLK(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_bar_start), "result word dropped or changed while stalled")

    // One word in flight: the input is closed right after an acceptance.
    `ASSERT_CLK(a_one_in_flight, s_valid && s_ready |=> !s_ready, "input accepted twice in a row")

    // Every closed bar holds at least one tick and a sane price range.
    `ASSERT_CLK(a_bar_sane, m_valid |-> m_tick_count != '0 && m_low_price <= m_high_price, "closed bar is empty or inverted")

    // Reset empties the result register.
    `ASSERT_ALWAYS(a_reset_clear, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind tick_to_ohlc_bar_aggregator_core ohlc_chk u_ohlc_chk (.*);

### tb/sv/tick_to_ohlc_bar_aggregator_core_test.sv
// Self-checking testbench for tick_to_ohlc_bar_aggregator_core: predicts each closed bar
// from the accepted ticks and compares it field by field with the m_ channel.
// Depends on ohlc_pkg and the core; reads no files.
`timescale 1ns / 100ps

module tick_to_ohlc_bar_aggregator_core_test;
    import ohlc_pkg::*;

    localparam int TICK_LATENCY = 56;
    localparam logic [TICKS_W-1:0] TICKS_FULL = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_FULL = '1;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;
    localparam logic [PERIOD_W-1:0] PERIOD_DAY = 37'd86400000000;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    typedef struct packed {
        logic [TIME_W-1:0]   start;
        logic [PRICE_W-1:0]  open;
        logic [PRICE_W-1:0]  high;
        logic [PRICE_W-1:0]  low;
        logic [PRICE_W-1:0]  close;
        logic [TICKS_W-1:0]  count;
        logic [SPREAD_W-1:0] mean;
        logic [SPREAD_W-1:0] peak;
    } bar_t;

    typedef struct {
        bit                  active;
        logic [TIME_W-1:0]   start;
        logic [PRICE_W-1:0]  open;
        logic [PRICE_W-1:0]  high;
        logic [PRICE_W-1:0]  low;
        logic [PRICE_W-1:0]  close;
        logic [TICKS_W-1:0]  ticks;
        logic [TOTAL_W-1:0]  total;
        logic [SPREAD_W-1:0] peak;
    } forming_bar_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_we = 1'b0;
    logic [PERIOD_W-1:0] cfg_wdata = '0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [TIME_W-1:0]   s_tick_time = '0;
    logic [PRICE_W-1:0]  s_bid_price = '0;
    logic [SPREAD_W-1:0] s_spread = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [TIME_W-1:0]   m_bar_start;
    logic [PRICE_W-1:0]  m_open_price;
    logic [PRICE_W-1:0]  m_high_price;
    logic [PRICE_W-1:0]  m_low_price;
    logic [PRICE_W-1:0]  m_close_price;
    logic [TICKS_W-1:0]  m_tick_count;
    logic [SPREAD_W-1:0] m_spread_mean;
    logic [SPREAD_W-1:0] m_spread_peak;

    // Predictor state: the period in force and the bar being formed.
    logic [PERIOD_W-1:0] bar_period = PERIOD_RESET;
    forming_bar_t        forming = '{default: '0};
    bar_t                closed_bars[$];
    int                  bars_checked = 0;
    int                  mismatches = 0;
    int                  random_ticks = 0;
    bit                  idle_on = 1'b1;

    tick_to_ohlc_bar_aggregator_core DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_tick_time   (s_tick_time),
        .s_bid_price   (s_bid_price),
        .s_spread      (s_spread),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_bar_start   (m_bar_start),
        .m_open_price  (m_open_price),
        .m_high_price  (m_high_price),
        .m_low_price   (m_low_price),
        .m_close_price (m_close_price),
        .m_tick_count  (m_tick_count),
        .m_spread_mean (m_spread_mean),
        .m_spread_peak (m_spread_peak)
    );

    always #5 aclk = ~aclk;

    // Closes the forming bar when the tick falls into another bar, then folds the tick in.
    function automatic void absorb_tick(input logic [TIME_W-1:0] t,
                                        input logic [PRICE_W-1:0] bid,
                                        input logic [SPREAD_W-1:0] spr);
        logic [63:0] period;
        logic [63:0] t64;
        logic [63:0] mean;
        logic [TIME_W-1:0] start;
        bar_t bar;
        period = 64'(bar_period);
        if (period == 0) begin
            period = 64'd1;
        end
        t64 = 64'(t);
        start = TIME_W'(t64 - (t64 % period));
        if (forming.active && start != forming.start) begin
            mean = '0;
            if (forming.ticks != 0) begin
                mean = 64'(forming.total) / 64'(forming.ticks);
            end
            if (mean > 64'hFFFF) begin
                mean = 64'hFFFF;
            end
            bar.start = forming.start;
            bar.open  = forming.open;
            bar.high  = forming.high;
            bar.low   = forming.low;
            bar.close = forming.close;
            bar.count = forming.ticks;
            bar.mean  = SPREAD_W'(mean);
            bar.peak  = forming.peak;
            closed_bars = {closed_bars, bar};
            forming.active = 1'b0;
        end
        if (!forming.active) begin
            forming.active = 1'b1;
            forming.start  = start;
            forming.open   = bid;
            forming.high   = bid;
            forming.low    = bid;
            forming.close  = bid;
            forming.ticks  = '0;
            forming.total  = '0;
            forming.peak   = '0;
        end
        if (bid > forming.high) begin
            forming.high = bid;
        end
        if (bid < forming.low) begin
            forming.low = bid;
        end
        forming.close = bid;
        if (forming.ticks != TICKS_FULL) begin
            forming.ticks++;
        end
        if (forming.total > TOTAL_FULL - TOTAL_W'(spr)) begin
            forming.total = TOTAL_FULL;
        end else begin
            forming.total = forming.total + TOTAL_W'(spr);
        end
        if (spr > forming.peak) begin
            forming.peak = spr;
        end
    endfunction

    function automatic void report_field(input string label, input logic [63:0] want,
                                         input logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("bar %0d %s: expected 0x%0h actual 0x%0h",
                         bars_checked, label, want, got);
            end
        end
    endfunction

    always @(posedge aclk) begin : check_bars
        bar_t want;
        if (aresetn && m_valid && m_ready) begin
            if (closed_bars.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("bar %0d: unexpected word, start 0x%0h", bars_checked,
                             m_bar_start);
                end
            end else begin
                want = closed_bars.pop_front();
                report_field("bar_start", 64'(want.start), 64'(m_bar_start));
                report_field("open_price", 64'(want.open), 64'(m_open_price));
                report_field("high_price", 64'(want.high), 64'(m_high_price));
                report_field("low_price", 64'(want.low), 64'(m_low_price));
                report_field("close_price", 64'(want.close), 64'(m_close_price));
                report_field("tick_count", 64'(want.count), 64'(m_tick_count));
                report_field("spread_mean", 64'(want.mean), 64'(m_spread_mean));
                report_field("spread_peak", 64'(want.peak), 64'(m_spread_peak));
            end
            bars_checked++;
        end
    end

    // The result side stalls in random bursts while idling is enabled.
    initial begin
        forever begin
            @(posedge aclk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // Valid is left high after acceptance so that a following word can be driven in the
    // same step; anything that waits instead lowers it here.
    task automatic bus_idle();
        s_valid <= 1'b0;
    endtask

    task automatic send_tick(input logic [TIME_W-1:0] t, input logic [PRICE_W-1:0] bid,
                             input logic [SPREAD_W-1:0] spr);
        int bursts;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            bursts = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 10) : 1;
            s_valid <= 1'b0;
            repeat (bursts) repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_tick_time <= t;
        s_bid_price <= bid;
        s_spread    <= spr;
        do @(posedge aclk); while (!s_ready);
        absorb_tick(t, bid, spr);
    endtask

    // Waits until every predicted bar has come out and the last word has been committed.
    task automatic drain_bars();
        bus_idle();
        while (closed_bars.size() != 0) @(posedge aclk);
        repeat (TICK_LATENCY + 8) @(posedge aclk);
    endtask

    task automatic write_period(input logic [PERIOD_W-1:0] value);
        drain_bars();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        bar_period = value;
    endtask

    // Random ticks around a moving cursor: mostly small steps inside a bar, with jumps,
    // steps backwards and arbitrary timestamps mixed in.
    task automatic random_ticks_run(input int count, input int drain_every);
        logic [63:0] now;
        logic [63:0] period;
        logic [63:0] step;
        logic [PRICE_W-1:0] bid;
        logic [SPREAD_W-1:0] spr;
        int r;
        period = (bar_period == 0) ? 64'd1 : 64'(bar_period);
        now = {$urandom, $urandom} & 64'(TIME_MAX);
        bid = PRICE_W'($urandom);
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            step = {$urandom, $urandom};
            if (r < 70) begin
                now = now + step % (period / 3 + 1);
            end else if (r < 85) begin
                now = now + period * $urandom_range(1, 3) + step % period;
            end else if (r < 92) begin
                now = now - step % (2 * period + 1);
            end else if (r < 97) begin
                now = step;
            end else if (r == 97) begin
                now = '0;
            end else begin
                now = 64'(TIME_MAX);
            end
            now = now & 64'(TIME_MAX);
            r = $urandom_range(0, 9);
            if (r < 7) begin
                bid = bid + PRICE_W'($urandom_range(0, 400)) - PRICE_W'(200);
            end else if (r == 7) begin
                bid = PRICE_W'($urandom);
            end else begin
                bid = (r == 8) ? '0 : '1;
            end
            r = $urandom_range(0, 9);
            spr = (r == 0) ? '0 : (r == 1) ? '1 : SPREAD_W'($urandom);
            send_tick(TIME_W'(now), bid, spr);
            random_ticks++;
            if (drain_every > 0 && (i + 1) % drain_every == 0) begin
                drain_bars();
            end
        end
    endtask

    task automatic test_default_period_bars();
        send_tick('0, '0, '0);
        send_tick(TIME_W'(59999999), '1, '1);
        send_tick(TIME_W'(60000000), PRICE_W'(24'h123456), SPREAD_W'(1));
        // A tick earlier than the forming bar closes it as well.
        send_tick(TIME_W'(30000000), PRICE_W'(5), SPREAD_W'(7));
    endtask

    task automatic test_extreme_period_and_time();
        write_period(PERIOD_MAX);
        send_tick(TIME_MAX, '1, '1);
        send_tick(TIME_MAX - 1, '0, SPREAD_W'(16'h8000));
        send_tick('0, PRICE_W'(24'h800000), '0);
    endtask

    task automatic test_zero_period();
        // A zero period behaves as one microsecond: every distinct timestamp is a bar.
        write_period('0);
        send_tick(TIME_W'(5), PRICE_W'(100), SPREAD_W'(3));
        send_tick(TIME_W'(5), PRICE_W'(90), SPREAD_W'(4));
        send_tick(TIME_W'(6), PRICE_W'(110), SPREAD_W'(5));
        send_tick(TIME_W'(4), PRICE_W'(120), SPREAD_W'(6));
    endtask

    task automatic test_day_and_unit_periods();
        write_period(PERIOD_DAY);
        send_tick(TIME_W'(PERIOD_DAY) * 2, PRICE_W'(1000), SPREAD_W'(10));
        send_tick(TIME_W'(PERIOD_DAY) * 3 - 1, PRICE_W'(999), SPREAD_W'(11));
        send_tick(TIME_W'(PERIOD_DAY) * 3, PRICE_W'(1001), SPREAD_W'(12));
        write_period(PERIOD_W'(1));
        send_tick(TIME_W'(10), PRICE_W'(7), SPREAD_W'(1));
        send_tick(TIME_W'(10), PRICE_W'(8), SPREAD_W'(2));
        send_tick(TIME_W'(11), PRICE_W'(6), SPREAD_W'(3));
    endtask

    task automatic test_random_streams();
        logic [PERIOD_W-1:0] periods[8];
        int phase;
        periods = '{PERIOD_W'(1000), PERIOD_W'(1), '0, PERIOD_RESET, PERIOD_DAY,
                    PERIOD_MAX, PERIOD_W'(7), '0};
        phase = 0;
        while (random_ticks < 700) begin
            if (phase % 8 == 7) begin
                write_period(PERIOD_W'({$urandom, $urandom}));
            end else begin
                write_period(periods[phase % 8]);
            end
            random_ticks_run(110, 0);
            phase++;
        end
    endtask

    task automatic test_sender_waits_for_results();
        write_period(PERIOD_W'(500));
        random_ticks_run(60, 12);
    endtask

    task automatic test_unthrottled_tail();
        write_period(PERIOD_W'(250));
        idle_on = 1'b0;
        random_ticks_run(150, 0);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_default_period_bars();
        test_extreme_period_and_time();
        test_zero_period();
        test_day_and_unit_periods();
        test_random_streams();
        test_sender_waits_for_results();
        test_unthrottled_tail();
        drain_bars();
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #10000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

### filelist.f
+incdir+src
src/ohlc_pkg.sv
src/ohlc_div.sv
src/ohlc_ctrl.sv
src/ohlc_dp.sv
src/tick_to_ohlc_bar_aggregator_core.sv
src/ohlc_chk.sv
tb/sv/tick_to_ohlc_bar_aggregator_core_test.sv
